// ===== rtl/core/imh_pkg.sv =====
package imh_pkg;

   localparam int NUM_ITEMS   = 1024;
   localparam int ID_BITS     = $clog2(NUM_ITEMS);
   localparam int CNT_BITS    = ID_BITS + 1;
   localparam int KEY_BITS    = 31;
   localparam int KIND_BITS   = 2;
   localparam int STATUS_BITS = 2;

   // A position entry equal to the heap capacity marks an id as absent.
   localparam logic [CNT_BITS-1:0] ABSENT = CNT_BITS'(NUM_ITEMS);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_INSERT   = 2'd0,
      KIND_POP      = 2'd1,
      KIND_DECREASE = 2'd2
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_IGNORED = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [KEY_BITS-1:0] key;
   } entry_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_START_INS,
      OP_START_DEC,
      OP_POP_TAKE,
      OP_UP_READ,
      OP_UP_MOVE,
      OP_DN_READ,
      OP_DN_MOVE,
      OP_PLACE,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic     clear_done;
      kind_type kind;
      logic     present;
      logic     full;
      logic     empty;
      logic     last_one;
      logic     at_root;
      logic     no_left;
      logic     up_swap;
      logic     dn_swap;
      logic     rsp_free;
   } stat_type;

endpackage

// ===== rtl/core/imh_if.sv =====
interface imh_req_if;
   logic                                valid;
   logic                                ready;
   logic [imh_pkg::KIND_BITS-1:0]       kind;
   logic [imh_pkg::ID_BITS-1:0]         item_id;
   logic [imh_pkg::KEY_BITS-1:0]        key;
   modport source (output valid, kind, item_id, key, input ready);
   modport sink (input valid, kind, item_id, key, output ready);
endinterface

interface imh_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [imh_pkg::STATUS_BITS-1:0]     status;
   logic [imh_pkg::ID_BITS-1:0]         out_id;
   logic [imh_pkg::KEY_BITS-1:0]        out_key;
   modport source (output valid, status, out_id, out_key, input ready);
   modport sink (input valid, status, out_id, out_key, output ready);
endinterface

// ===== rtl/core/indexed_min_heap_decrease_key.sv =====
// Channel   Direction  Fields
// req       in         kind, item_id, key
// rsp       out        status, out_id, out_key
//
// One item at a time. Each level that the sift moves takes one heap memory read
// and one write. After reset the position table is cleared entry by entry,
// and req.ready rises once the clear is done.
// The result waits in an output register; a stalled rsp holds the next item
// only at its final step.
module indexed_min_heap_decrease_key (
   input  logic      clock,
   input  logic      reset,
   imh_req_if.sink   req,
   imh_rsp_if.source rsp
);

   imh_pkg::cmd_type  cmd;
   imh_pkg::stat_type stat;
   logic              ready;

   assign req.ready = ready;

   imh_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   imh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_kind    (req.kind),
      .req_item_id (req.item_id),
      .req_key     (req.key),
      .cmd         (cmd),
      .stat        (stat),
      .rsp         (rsp)
   );

endmodule

// ===== rtl/core/imh_datapath.sv =====
module imh_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [imh_pkg::KIND_BITS-1:0] req_kind,
   input  logic [imh_pkg::ID_BITS-1:0]   req_item_id,
   input  logic [imh_pkg::KEY_BITS-1:0]  req_key,
   input  imh_pkg::cmd_type              cmd,
   output imh_pkg::stat_type             stat,
   imh_rsp_if.source                     rsp
);

   imh_pkg::entry_type heap_mem [imh_pkg::NUM_ITEMS];
   logic [imh_pkg::CNT_BITS-1:0] pos_mem [imh_pkg::NUM_ITEMS];

   imh_pkg::entry_type ha_ff, hb_ff, cur_ff, cur_in, hw_data;
   logic [imh_pkg::CNT_BITS-1:0] prd_ff, pw_data;
   logic [imh_pkg::ID_BITS-1:0] ha_addr, hb_addr, hw_addr, pw_addr;
   logic hw_en, pw_en;

   imh_pkg::kind_type kind_ff;
   logic [imh_pkg::ID_BITS-1:0] id_ff;
   logic [imh_pkg::KEY_BITS-1:0] key_ff;
   logic [imh_pkg::CNT_BITS-1:0] count_ff, count_in, clr_ff, clr_in;
   logic [imh_pkg::ID_BITS-1:0] hole_ff, hole_in;
   logic [imh_pkg::ID_BITS-1:0] res_id_ff, res_id_in;
   logic [imh_pkg::KEY_BITS-1:0] res_key_ff, res_key_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [imh_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [imh_pkg::ID_BITS-1:0] rsp_id_ff;
   logic [imh_pkg::KEY_BITS-1:0] rsp_key_ff;

   logic [imh_pkg::ID_BITS-1:0] parent, last_idx;
   logic [imh_pkg::CNT_BITS-1:0] left_idx, right_idx;
   logic take_l, take_r, rsp_free;

   assign parent    = (hole_ff - imh_pkg::ID_BITS'(1)) >> 1;
   assign last_idx  = count_ff[imh_pkg::ID_BITS-1:0] - imh_pkg::ID_BITS'(1);
   assign left_idx  = {hole_ff, 1'b1};
   assign right_idx = left_idx + imh_pkg::CNT_BITS'(1);

   assign take_l = ha_ff.key < cur_ff.key;
   assign take_r = (right_idx < count_ff) && (hb_ff.key < cur_ff.key)
                   && (!take_l || (hb_ff.key < ha_ff.key));
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      stat.clear_done = (clr_ff == imh_pkg::ABSENT);
      stat.kind       = kind_ff;
      // Absent is the capacity, which no live slot reaches.
      stat.present    = (prd_ff < count_ff);
      stat.full       = (count_ff == imh_pkg::ABSENT);
      stat.empty      = (count_ff == '0);
      stat.last_one   = (count_ff == imh_pkg::CNT_BITS'(1));
      stat.at_root    = (hole_ff == '0);
      stat.no_left    = (left_idx >= count_ff);
      stat.up_swap    = (cur_ff.key < ha_ff.key);
      stat.dn_swap    = take_l || take_r;
      stat.rsp_free   = rsp_free;
   end

   always_comb begin
      ha_addr = '0;
      hb_addr = last_idx;
      if (cmd.op == imh_pkg::OP_UP_READ) begin
         ha_addr = parent;
      end else if (cmd.op == imh_pkg::OP_DN_READ) begin
         ha_addr = left_idx[imh_pkg::ID_BITS-1:0];
         hb_addr = right_idx[imh_pkg::ID_BITS-1:0];
      end
   end

   always_comb begin
      hw_en      = 1'b0;
      hw_addr    = hole_ff;
      hw_data    = cur_ff;
      pw_en      = 1'b0;
      pw_addr    = cur_ff.id;
      pw_data    = {1'b0, hole_ff};
      count_in   = count_ff;
      clr_in     = clr_ff;
      hole_in    = hole_ff;
      cur_in     = cur_ff;
      res_id_in  = res_id_ff;
      res_key_in = res_key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      case (cmd.op)
         imh_pkg::OP_CLEAR: begin
            pw_en   = 1'b1;
            pw_addr = clr_ff[imh_pkg::ID_BITS-1:0];
            pw_data = imh_pkg::ABSENT;
            clr_in  = clr_ff + imh_pkg::CNT_BITS'(1);
         end
         imh_pkg::OP_ACCEPT: begin
            res_id_in  = '0;
            res_key_in = '0;
         end
         imh_pkg::OP_START_INS: begin
            cur_in   = '{id: id_ff, key: key_ff};
            hole_in  = count_ff[imh_pkg::ID_BITS-1:0];
            count_in = count_ff + imh_pkg::CNT_BITS'(1);
         end
         imh_pkg::OP_START_DEC: begin
            cur_in  = '{id: id_ff, key: key_ff};
            hole_in = prd_ff[imh_pkg::ID_BITS-1:0];
         end
         imh_pkg::OP_POP_TAKE: begin
            res_id_in  = ha_ff.id;
            res_key_in = ha_ff.key;
            pw_en      = 1'b1;
            pw_addr    = ha_ff.id;
            pw_data    = imh_pkg::ABSENT;
            count_in   = count_ff - imh_pkg::CNT_BITS'(1);
            cur_in     = hb_ff;
            hole_in    = '0;
         end
         imh_pkg::OP_UP_MOVE: begin
            hw_en   = 1'b1;
            hw_data = ha_ff;
            pw_en   = 1'b1;
            pw_addr = ha_ff.id;
            hole_in = parent;
         end
         imh_pkg::OP_DN_MOVE: begin
            hw_en   = 1'b1;
            pw_en   = 1'b1;
            if (take_r) begin
               hw_data = hb_ff;
               pw_addr = hb_ff.id;
               hole_in = right_idx[imh_pkg::ID_BITS-1:0];
            end else begin
               hw_data = ha_ff;
               pw_addr = ha_ff.id;
               hole_in = left_idx[imh_pkg::ID_BITS-1:0];
            end
         end
         imh_pkg::OP_PLACE: begin
            hw_en = 1'b1;
            pw_en = 1'b1;
         end
         imh_pkg::OP_RESULT: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (hw_en) begin
         heap_mem[hw_addr] <= hw_data;
      end
      ha_ff <= heap_mem[ha_addr];
      hb_ff <= heap_mem[hb_addr];
      if (pw_en) begin
         pos_mem[pw_addr] <= pw_data;
      end
      prd_ff <= pos_mem[req_item_id];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.op == imh_pkg::OP_ACCEPT) begin
         kind_ff <= imh_pkg::kind_type'(req_kind);
         id_ff   <= req_item_id;
         key_ff  <= req_key;
      end
      if (cmd.op == imh_pkg::OP_RESULT) begin
         rsp_status_ff <= cmd.status;
         rsp_id_ff     <= res_id_ff;
         rsp_key_ff    <= res_key_ff;
      end
      hole_ff    <= hole_in;
      cur_ff     <= cur_in;
      res_id_ff  <= res_id_in;
      res_key_ff <= res_key_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.status  = rsp_status_ff;
   assign rsp.out_id  = rsp_id_ff;
   assign rsp.out_key = rsp_key_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= imh_pkg::ABSENT)
      else $error("heap count beyond capacity");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == imh_pkg::OP_RESULT |-> rsp_free)
      else $error("result loaded over an untaken item");

   a_place_in_heap: assert property (@(posedge clock) disable iff (reset)
      cmd.op == imh_pkg::OP_PLACE |-> {1'b0, hole_ff} < count_ff)
      else $error("element placed outside the live heap");

endmodule

// ===== rtl/core/imh_controller.sv =====
module imh_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  imh_pkg::stat_type   stat,
   output imh_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOOKUP, S_UP, S_UPCMP, S_DOWN, S_DNCMP, S_PLACE, S_RESULT
   } state_type;

   state_type state_ff, state_in;
   imh_pkg::status_type st_ff, st_in;

   always_comb begin
      state_in  = state_ff;
      st_in     = st_ff;
      cmd.op    = imh_pkg::OP_NONE;
      cmd.status = st_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.op = imh_pkg::OP_CLEAR;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = imh_pkg::OP_ACCEPT;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            st_in    = imh_pkg::ST_IGNORED;
            state_in = S_RESULT;
            case (stat.kind)
               imh_pkg::KIND_INSERT: begin
                  if (stat.present) begin
                     st_in = imh_pkg::ST_IGNORED;
                  end else if (stat.full) begin
                     st_in = imh_pkg::ST_FULL;
                  end else begin
                     cmd.op   = imh_pkg::OP_START_INS;
                     st_in    = imh_pkg::ST_OK;
                     state_in = S_UP;
                  end
               end
               imh_pkg::KIND_POP: begin
                  if (stat.empty) begin
                     st_in = imh_pkg::ST_EMPTY;
                  end else begin
                     cmd.op = imh_pkg::OP_POP_TAKE;
                     st_in  = imh_pkg::ST_OK;
                     // Removing the only element leaves nothing to sift.
                     state_in = stat.last_one ? S_RESULT : S_DOWN;
                  end
               end
               imh_pkg::KIND_DECREASE: begin
                  if (stat.present) begin
                     cmd.op   = imh_pkg::OP_START_DEC;
                     st_in    = imh_pkg::ST_OK;
                     state_in = S_UP;
                  end
               end
               default: begin
               end
            endcase
         end
         S_UP: begin
            if (stat.at_root) begin
               state_in = S_PLACE;
            end else begin
               cmd.op   = imh_pkg::OP_UP_READ;
               state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            if (stat.up_swap) begin
               cmd.op   = imh_pkg::OP_UP_MOVE;
               state_in = S_UP;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_DOWN: begin
            if (stat.no_left) begin
               state_in = S_PLACE;
            end else begin
               cmd.op   = imh_pkg::OP_DN_READ;
               state_in = S_DNCMP;
            end
         end
         S_DNCMP: begin
            if (stat.dn_swap) begin
               cmd.op   = imh_pkg::OP_DN_MOVE;
               state_in = S_DOWN;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.op   = imh_pkg::OP_PLACE;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.op   = imh_pkg::OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         st_ff    <= imh_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

   a_ready_after_clear: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> stat.clear_done)
      else $error("item accepted before the position table was cleared");

endmodule

// ===== dv/imh_checker.sv =====
`timescale 1ns / 1ps

module imh_checker (
   input  logic clock,
   input  logic reset,
   imh_req_if   req,
   imh_rsp_if   rsp,
   output int   errors,
   output int   pending
);
   import imh_pkg::*;

   typedef struct {
      status_type          status;
      logic [ID_BITS-1:0]  out_id;
      logic [KEY_BITS-1:0] out_key;
   } outcome_type;

   logic [ID_BITS-1:0]  slot_id  [NUM_ITEMS];
   logic [KEY_BITS-1:0] slot_key [NUM_ITEMS];
   logic [CNT_BITS-1:0] where    [NUM_ITEMS];
   int                  fill;
   outcome_type         awaited [$];

   function automatic void trade(int a, int b);
      logic [ID_BITS-1:0]  tid;
      logic [KEY_BITS-1:0] tkey;
      tid = slot_id[a];
      tkey = slot_key[a];
      slot_id[a] = slot_id[b];
      slot_key[a] = slot_key[b];
      slot_id[b] = tid;
      slot_key[b] = tkey;
      where[slot_id[a]] = CNT_BITS'(a);
      where[slot_id[b]] = CNT_BITS'(b);
   endfunction

   function automatic void climb(int c);
      int p;
      while (c > 0) begin
         p = (c - 1) / 2;
         if (slot_key[c] < slot_key[p]) begin
            trade(c, p);
            c = p;
         end else begin
            break;
         end
      end
   endfunction

   function automatic void descend(int p);
      int best;
      int l;
      int r;
      forever begin
         best = p;
         l = 2 * p + 1;
         r = 2 * p + 2;
         if (l < fill && slot_key[l] < slot_key[p]) best = l;
         // A tie between the children goes to the left one.
         if (r < fill && slot_key[r] < slot_key[p])
            if (best == p || slot_key[r] < slot_key[l]) best = r;
         if (best == p) break;
         trade(p, best);
         p = best;
      end
   endfunction

   function automatic outcome_type apply_op(logic [KIND_BITS-1:0] kind,
                                            logic [ID_BITS-1:0] id,
                                            logic [KEY_BITS-1:0] key);
      outcome_type o;
      o.status = ST_IGNORED;
      o.out_id = '0;
      o.out_key = '0;
      case (kind)
         KIND_INSERT: begin
            if (where[id] == ABSENT) begin
               if (fill >= NUM_ITEMS) begin
                  o.status = ST_FULL;
               end else begin
                  slot_id[fill] = id;
                  slot_key[fill] = key;
                  where[id] = CNT_BITS'(fill);
                  fill++;
                  climb(fill - 1);
                  o.status = ST_OK;
               end
            end
         end
         KIND_POP: begin
            if (fill == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.out_id = slot_id[0];
               o.out_key = slot_key[0];
               where[slot_id[0]] = ABSENT;
               fill--;
               if (fill > 0) begin
                  slot_id[0] = slot_id[fill];
                  slot_key[0] = slot_key[fill];
                  where[slot_id[0]] = '0;
                  descend(0);
               end
               o.status = ST_OK;
            end
         end
         KIND_DECREASE: begin
            if (where[id] != ABSENT && where[id] < fill) begin
               slot_key[where[id]] = key;
               climb(where[id]);
               o.status = ST_OK;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      int bad;
      bad = 0;
      if (reset) begin
         for (int i = 0; i < NUM_ITEMS; i++) where[i] = ABSENT;
         fill = 0;
         awaited.delete();
         errors <= 0;
      end else begin
         if (req.valid && req.ready)
            awaited.insert(awaited.size(), apply_op(req.kind, req.item_id, req.key));
         if (rsp.valid && rsp.ready) begin
            got.status = status_type'(rsp.status);
            got.out_id = rsp.out_id;
            got.out_key = rsp.out_key;
            if (awaited.size() == 0) begin
               $error("result with none expected: status %0d", rsp.status);
               bad++;
            end else begin
               want = awaited.pop_front();
               if (got.status != want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  bad++;
               end
               if (got.out_id != want.out_id) begin
                  $error("out_id: expected %0d, got %0d", want.out_id, got.out_id);
                  bad++;
               end
               if (got.out_key != want.out_key) begin
                  $error("out_key: expected %0d, got %0d", want.out_key, got.out_key);
                  bad++;
               end
            end
         end
         errors <= errors + bad;
      end
      pending <= awaited.size();
   end

   initial begin
      errors = 0;
      pending = 0;
   end

endmodule

// ===== dv/indexed_min_heap_decrease_key_test.sv =====
`timescale 1ns / 1ps

module indexed_min_heap_decrease_key_test;
   import imh_pkg::*;

   // The one kind code that the block treats as no operation.
   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

   logic clock;
   logic reset;
   int   errors;
   int   pending;
   logic quiet;

   imh_req_if req ();
   imh_rsp_if rsp ();

   indexed_min_heap_decrease_key uut (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp)
   );

   imh_checker check (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .rsp    (rsp),
      .errors (errors),
      .pending(pending)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // The valid line is only lowered when a gap follows, so it never sees two
   // assignments in the same step.
   task automatic send(logic [KIND_BITS-1:0] kind, logic [ID_BITS-1:0] id,
                       logic [KEY_BITS-1:0] key);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.kind <= kind;
      req.item_id <= id;
      req.key <= key;
      do @(posedge clock); while (!req.ready);
   endtask

   function automatic logic [KEY_BITS-1:0] draw_key();
      if ($urandom_range(0, 1)) return KEY_BITS'($urandom_range(0, 15));
      return KEY_BITS'($urandom());
   endfunction

   task automatic random_op(int id_top);
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) send(KIND_INSERT, ID_BITS'($urandom_range(0, id_top)), draw_key());
      else if (r < 75) send(KIND_POP, ID_BITS'($urandom()), KEY_BITS'($urandom()));
      else if (r < 97) send(KIND_DECREASE, ID_BITS'($urandom_range(0, id_top)), draw_key());
      else send(KIND_UNUSED, ID_BITS'($urandom()), KEY_BITS'($urandom()));
   endtask

   always begin
      int k;
      int taken;
      taken = 0;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         k = quiet ? 0 : $urandom_range(0, 4);
         // One long hold-off lets the block fill up and stall its input.
         if (taken == 150) k = 400;
         if (k > 0) begin
            rsp.ready <= 1'b0;
            repeat (k) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         taken++;
      end
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      quiet = 1'b0;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.kind <= KIND_INSERT;
      req.item_id <= '0;
      req.key <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pop, unknown kind, extreme fields, duplicates, ties.
      send(KIND_POP, '0, '0);
      send(KIND_UNUSED, '1, '1);
      send(KIND_DECREASE, 10'd5, 31'd3);
      send(KIND_INSERT, '0, '0);
      send(KIND_INSERT, '1, '1);
      send(KIND_INSERT, '1, 31'd7);
      send(KIND_INSERT, 10'd5, 31'd100);
      send(KIND_INSERT, 10'd6, 31'd100);
      send(KIND_INSERT, 10'd7, 31'd100);
      send(KIND_DECREASE, 10'd7, 31'd50);
      send(KIND_DECREASE, 10'd5, 31'd200);
      send(KIND_DECREASE, '1, 31'd0);
      send(KIND_INSERT, 10'h2AA, 31'h2AAAAAAA);
      send(KIND_INSERT, 10'h155, 31'h55555555);
      repeat (9) send(KIND_POP, '1, '1);
      send(KIND_DECREASE, 10'd5, 31'd1);

      for (int i = 0; i < 700; i++) begin
         if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
         random_op($urandom_range(0, 9) == 0 ? 1023 : 47);
      end
      quiet = 1'b0;

      // Sender pauses until the block has answered everything.
      if (req.valid) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      while (pending != 0) @(posedge clock);

      // Fill the heap completely, then work on it.
      for (int i = 0; i < NUM_ITEMS; i++) begin
         if (i % 128 == 0) quiet = ($urandom_range(0, 1) == 0);
         send(KIND_INSERT, ID_BITS'(i), draw_key());
      end
      for (int i = 0; i < 120; i++) begin
         if ($urandom_range(0, 1)) send(KIND_POP, '0, '0);
         else send(KIND_DECREASE, ID_BITS'($urandom()), draw_key());
      end
      quiet = 1'b0;
      req.valid <= 1'b0;
      @(posedge clock);

      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
